[design/assert_macros.svh]
// assertion macros for the chunk allocator
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`endif

[design/fpca_pkg.sv]
// shared types and constants for the fit-policy chunk allocator
// no dependencies
`timescale 1ns / 1ps
package fpca_pkg;
   localparam int FREE_ENTRIES_DEF = 64;
   localparam int USED_ENTRIES_DEF = 64;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 2'd2;
   localparam logic [1:0] POL_BEST = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;
   localparam logic OP_ALLOC = 1'b0;
   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_UNKNOWN = 2'd1, ST_FULL = 2'd2, ST_EXHAUSTED = 2'd3
   } status_type;
endpackage

[design/fit_policy_chunk_allocator.sv]
// top level of the fit-policy chunk allocator: tables, scan sequencer, result
// depends on fpca_pkg and assert_macros.svh
`timescale 1ns / 1ps
// A transaction is accepted when start is high and busy is low; one result
// follows on rsp_valid for one cycle and cannot be stalled. Each transaction
// first scans both valid bit vectors for free slots, then walks the free
// table (allocate) or the used table (release) one entry per cycle through a
// synchronous memory with a registered read port, then writes back. Config
// writes go straight to registers; writing heap_base also reloads the heap
// break. No clearing pass: table contents are only trusted under their valid
// bits.
module fit_policy_chunk_allocator #(
   parameter int FREE_ENTRIES = fpca_pkg::FREE_ENTRIES_DEF,
   parameter int USED_ENTRIES = fpca_pkg::USED_ENTRIES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_op,
   input  logic [23:0] req_request_size,
   input  logic [31:0] req_release_address,
   output logic rsp_valid,
   output logic [31:0] rsp_granted_address,
   output logic [1:0] rsp_status,
   input  logic csr_write_enable,
   input  logic [fpca_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fpca_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import fpca_pkg::*;
`include "assert_macros.svh"

   localparam int FW = $clog2(FREE_ENTRIES);
   localparam int UW = $clog2(USED_ENTRIES);
   localparam int MW = (FW > UW) ? FW : UW;

   typedef enum logic [2:0] {S_IDLE, S_SLOT, S_SCAN, S_LAST, S_WRITE} state_type;

   // table memories
   logic [31:0] free_addr_mem [FREE_ENTRIES];
   logic [23:0] free_size_mem [FREE_ENTRIES];
   logic [15:0] free_stamp_mem [FREE_ENTRIES];
   logic [31:0] used_addr_mem [USED_ENTRIES];
   logic [23:0] used_size_mem [USED_ENTRIES];
   logic [FREE_ENTRIES-1:0] free_valid_ff;
   logic [USED_ENTRIES-1:0] used_valid_ff;

   state_type state_ff;
   logic [1:0] policy_ff;
   logic [31:0] limit_ff, brk_ff;
   logic [15:0] stamp_ff;
   logic op_ff;
   logic [23:0] size_ff;
   logic [31:0] raddr_ff;
   // scan counter, one wider so it can reach the depth
   logic [MW:0] cnt_ff;
   // registered read address of the previous cycle (entry index in flight)
   logic [MW-1:0] rd_idx_ff;
   logic rd_ok_ff;
   logic [31:0] fa_q, ua_q;
   logic [23:0] fs_q, us_q;
   logic [15:0] fst_q;
   // free slot and used slot found
   logic fslot_ok_ff, uslot_ok_ff;
   logic [FW-1:0] fslot_ff;
   logic [UW-1:0] uslot_ff;
   // best candidate
   logic hit_ff;
   logic [MW-1:0] hit_idx_ff;
   logic [31:0] hit_addr_ff;
   logic [23:0] hit_size_ff, hit_slack_ff;
   logic [15:0] hit_age_ff;
   logic rsp_valid_ff;
   logic [31:0] rsp_addr_ff;
   logic [1:0] rsp_status_ff;

   // first free slot search over valid bits
   logic fslot_ok, uslot_ok;
   logic [FW-1:0] fslot;
   logic [UW-1:0] uslot;
   always_comb begin
      fslot_ok = 1'b0;
      fslot = '0;
      for (int i = FREE_ENTRIES - 1; i >= 0; i--) begin
         if (!free_valid_ff[i]) begin
            fslot_ok = 1'b1;
            fslot = FW'(i);
         end
      end
      uslot_ok = 1'b0;
      uslot = '0;
      for (int i = USED_ENTRIES - 1; i >= 0; i--) begin
         if (!used_valid_ff[i]) begin
            uslot_ok = 1'b1;
            uslot = UW'(i);
         end
      end
   end

   // candidate evaluation of the entry read last cycle
   logic cand_fit, better;
   logic [23:0] cand_slack;
   logic [15:0] cand_age;
   logic used_match;
   always_comb begin
      cand_fit = rd_ok_ff && free_valid_ff[rd_idx_ff[FW-1:0]] && (fs_q >= size_ff);
      cand_slack = fs_q - size_ff;
      cand_age = stamp_ff - fst_q;
      if (!hit_ff) begin
         better = 1'b1;
      end else if (policy_ff == POL_BEST) begin
         better = (cand_slack < hit_slack_ff) ||
                  (cand_slack == hit_slack_ff && cand_age > hit_age_ff);
      end else if (policy_ff == POL_WORST) begin
         better = (cand_slack > hit_slack_ff) ||
                  (cand_slack == hit_slack_ff && cand_age > hit_age_ff);
      end else begin
         better = cand_age > hit_age_ff;
      end
      used_match = rd_ok_ff && used_valid_ff[rd_idx_ff[UW-1:0]] && (ua_q == raddr_ff);
   end

   logic [MW:0] scan_len;
   assign scan_len = (op_ff == OP_ALLOC) ? (MW+1)'(FREE_ENTRIES) : (MW+1)'(USED_ENTRIES);

   // synchronous reads, one per table
   always_ff @(posedge clock) begin
      fa_q <= free_addr_mem[cnt_ff[FW-1:0]];
      fs_q <= free_size_mem[cnt_ff[FW-1:0]];
      fst_q <= free_stamp_mem[cnt_ff[FW-1:0]];
      ua_q <= used_addr_mem[cnt_ff[UW-1:0]];
      us_q <= used_size_mem[cnt_ff[UW-1:0]];
   end

   // write-back decisions
   logic [32:0] brk_sum;
   logic [23:0] rem;
   assign brk_sum = {1'b0, brk_ff} + {9'd0, size_ff};
   assign rem = hit_size_ff - size_ff;

   logic do_split, do_take, do_heap, do_rel;
   logic [31:0] grant;
   always_comb begin
      do_split = 1'b0;
      do_take = 1'b0;
      do_heap = 1'b0;
      do_rel = 1'b0;
      grant = '0;
      if (op_ff == OP_ALLOC) begin
         if (uslot_ok_ff && hit_ff) begin
            if (hit_size_ff > size_ff) begin
               do_split = 1'b1;
               grant = hit_addr_ff + {8'd0, rem};
            end else begin
               do_take = 1'b1;
               grant = hit_addr_ff;
            end
         end else if (uslot_ok_ff && brk_sum <= {1'b0, limit_ff}) begin
            do_heap = 1'b1;
            grant = brk_ff;
         end
      end else begin
         do_rel = hit_ff && fslot_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE) begin
         if (do_split) begin
            free_size_mem[hit_idx_ff[FW-1:0]] <= rem;
         end
         if (do_split || do_take || do_heap) begin
            used_addr_mem[uslot_ff] <= grant;
            used_size_mem[uslot_ff] <= size_ff;
         end
         if (do_rel) begin
            free_addr_mem[fslot_ff] <= hit_addr_ff;
            free_size_mem[fslot_ff] <= hit_size_ff;
            free_stamp_mem[fslot_ff] <= stamp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         policy_ff <= '0;
         limit_ff <= '1;
         brk_ff <= '0;
         stamp_ff <= '0;
         free_valid_ff <= '0;
         used_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         rd_ok_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FIT_POLICY: policy_ff <= csr_write_data[1:0];
               CSR_HEAP_BASE: brk_ff <= csr_write_data;
               CSR_HEAP_LIMIT: limit_ff <= csr_write_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff <= req_op;
                  size_ff <= req_request_size;
                  raddr_ff <= req_release_address;
                  state_ff <= S_SLOT;
               end
            end
            S_SLOT: begin
               fslot_ok_ff <= fslot_ok;
               fslot_ff <= fslot;
               uslot_ok_ff <= uslot_ok;
               uslot_ff <= uslot;
               hit_ff <= 1'b0;
               cnt_ff <= '0;
               rd_ok_ff <= 1'b0;
               state_ff <= S_SCAN;
            end
            S_SCAN, S_LAST: begin
               rd_idx_ff <= cnt_ff[MW-1:0];
               rd_ok_ff <= (state_ff == S_SCAN);
               cnt_ff <= cnt_ff + 1'b1;
               if (op_ff == OP_ALLOC) begin
                  if (cand_fit && better) begin
                     hit_ff <= 1'b1;
                     hit_idx_ff <= rd_idx_ff;
                     hit_addr_ff <= fa_q;
                     hit_size_ff <= fs_q;
                     hit_slack_ff <= cand_slack;
                     hit_age_ff <= cand_age;
                  end
               end else if (used_match && !hit_ff) begin
                  hit_ff <= 1'b1;
                  hit_idx_ff <= rd_idx_ff;
                  hit_addr_ff <= ua_q;
                  hit_size_ff <= us_q;
               end
               if (state_ff == S_LAST) begin
                  state_ff <= S_WRITE;
               end else if (cnt_ff == scan_len - 1'b1) begin
                  state_ff <= S_LAST;
               end
            end
            S_WRITE: begin
               rsp_valid_ff <= 1'b1;
               rsp_addr_ff <= grant;
               state_ff <= S_IDLE;
               if (op_ff == OP_ALLOC) begin
                  if (!uslot_ok_ff) begin
                     rsp_status_ff <= ST_FULL;
                  end else if (!hit_ff && !do_heap) begin
                     rsp_status_ff <= ST_EXHAUSTED;
                  end else begin
                     rsp_status_ff <= ST_OK;
                  end
                  if (do_take) begin
                     free_valid_ff[hit_idx_ff[FW-1:0]] <= 1'b0;
                  end
                  if (do_heap) begin
                     brk_ff <= brk_sum[31:0];
                  end
                  if (do_split || do_take || do_heap) begin
                     used_valid_ff[uslot_ff] <= 1'b1;
                  end
               end else begin
                  rsp_addr_ff <= '0;
                  if (!hit_ff) begin
                     rsp_status_ff <= ST_UNKNOWN;
                  end else if (!fslot_ok_ff) begin
                     rsp_status_ff <= ST_FULL;
                  end else begin
                     rsp_status_ff <= ST_OK;
                     free_valid_ff[fslot_ff] <= 1'b1;
                     used_valid_ff[hit_idx_ff[UW-1:0]] <= 1'b0;
                     stamp_ff <= stamp_ff + 16'd1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status = rsp_status_ff;

   `ASSERT_NEXT(a_write_gives_rsp, clock, reset, state_ff == S_WRITE, rsp_valid, "no result after write-back")
   `ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_granted_address == 32'd0, "error with address")
endmodule

[tb/tb_fit_policy_chunk_allocator.sv]
// self-checking testbench for the fit-policy chunk allocator
// depends on fpca_pkg and the fit_policy_chunk_allocator top level
`timescale 1ns / 1ps

module tb_fit_policy_chunk_allocator;
   import fpca_pkg::*;

   localparam int NFREE = FREE_ENTRIES_DEF;
   localparam int NUSED = USED_ENTRIES_DEF;
   localparam int WATCHDOG_CYCLES = 1000000;
   localparam int SETTLE_CYCLES = 80;

   typedef struct {
      logic [31:0] granted;
      status_type  status;
   } alloc_result_type;

   // shadow of the allocator tables, predicts one result per transaction
   class chunk_scoreboard_type;
      logic [31:0] free_addr [NFREE];
      logic [23:0] free_len [NFREE];
      logic [15:0] free_age_tag [NFREE];
      bit          free_live [NFREE];
      logic [31:0] used_addr [NUSED];
      logic [23:0] used_len [NUSED];
      bit          used_live [NUSED];
      logic [15:0] stamp_next;
      logic [31:0] brk;
      logic [1:0]  policy;
      logic [31:0] limit;
      alloc_result_type pending[$];
      int mismatches;
      int checked;
      int n_status [4];

      function void clear();
         for (int i = 0; i < NFREE; i++) free_live[i] = 0;
         for (int i = 0; i < NUSED; i++) used_live[i] = 0;
         stamp_next = '0;
         brk = '0;
         policy = '0;
         limit = 32'hFFFF_FFFF;
         mismatches = 0;
         checked = 0;
         for (int i = 0; i < 4; i++) n_status[i] = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         if (idx == CSR_FIT_POLICY) policy = data[1:0];
         else if (idx == CSR_HEAP_BASE) brk = data;
         else if (idx == CSR_HEAP_LIMIT) limit = data;
      endfunction

      // list-order age, larger means earlier in the free list
      function logic [15:0] age(int i);
         return stamp_next - free_age_tag[i];
      endfunction

      function int choose_chunk(logic [23:0] want);
         int pick;
         logic [23:0] s, bs;
         bit better;
         pick = -1;
         for (int i = 0; i < NFREE; i++) begin
            if (!free_live[i] || free_len[i] < want) continue;
            if (pick < 0) begin
               pick = i;
               continue;
            end
            s = free_len[i] - want;
            bs = free_len[pick] - want;
            if (policy == POL_BEST)
               better = s < bs || (s == bs && age(i) > age(pick));
            else if (policy == POL_WORST)
               better = s > bs || (s == bs && age(i) > age(pick));
            else
               better = age(i) > age(pick);
            if (better) pick = i;
         end
         return pick;
      endfunction

      // note an accepted transaction and queue its expected result
      function void note_request(logic op, logic [23:0] want, logic [31:0] addr);
         alloc_result_type r;
         int u, f;
         r.granted = '0;
         r.status = ST_OK;
         u = -1;
         f = -1;
         if (op == OP_ALLOC) begin
            for (int i = 0; i < NUSED && u < 0; i++) if (!used_live[i]) u = i;
            if (u < 0) r.status = ST_FULL;
            else begin
               f = choose_chunk(want);
               if (f >= 0) begin
                  if (free_len[f] > want) begin
                     r.granted = free_addr[f] + (free_len[f] - want);
                     free_len[f] = free_len[f] - want;
                  end else begin
                     r.granted = free_addr[f];
                     free_live[f] = 0;
                  end
               end else if ({1'b0, brk} + want > {1'b0, limit}) begin
                  r.status = ST_EXHAUSTED;
               end else begin
                  r.granted = brk;
                  brk = brk + want;
               end
               if (r.status == ST_OK) begin
                  used_addr[u] = r.granted;
                  used_len[u] = want;
                  used_live[u] = 1;
               end
            end
         end else begin
            for (int i = 0; i < NUSED && u < 0; i++)
               if (used_live[i] && used_addr[i] == addr) u = i;
            if (u < 0) r.status = ST_UNKNOWN;
            else begin
               for (int i = 0; i < NFREE && f < 0; i++) if (!free_live[i]) f = i;
               if (f < 0) r.status = ST_FULL;
               else begin
                  free_addr[f] = used_addr[u];
                  free_len[f] = used_len[u];
                  free_age_tag[f] = stamp_next;
                  free_live[f] = 1;
                  stamp_next = stamp_next + 16'd1;
                  used_live[u] = 0;
               end
            end
         end
         pending = {pending, r};
      endfunction

      function void check_result(logic [31:0] granted, logic [1:0] status);
         alloc_result_type r;
         if (pending.size() == 0) begin
            $error("result with no transaction outstanding: addr %h status %0d",
                   granted, status);
            mismatches++;
            return;
         end
         r = pending.pop_front();
         checked++;
         n_status[r.status]++;
         if (granted !== r.granted) begin
            $error("granted_address expected %h actual %h", r.granted, granted);
            mismatches++;
         end
         if (status !== r.status) begin
            $error("status expected %0d actual %0d", r.status, status);
            mismatches++;
         end
      endfunction

      // a live used address most of the time, so releases hit real chunks
      function logic [31:0] some_used_address();
         int cand[$];
         for (int i = 0; i < NUSED; i++) if (used_live[i]) cand = {cand, i};
         if (cand.size() == 0) return $urandom;
         return used_addr[cand[$urandom_range(cand.size() - 1)]];
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_op;
   logic [23:0] req_request_size;
   logic [31:0] req_release_address;
   logic rsp_valid;
   logic [31:0] rsp_granted_address;
   logic [1:0] rsp_status;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   chunk_scoreboard_type sb;
   int sender_idle_pct;
   int sent;
   int cycles;

   fit_policy_chunk_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_request_size(req_request_size),
      .req_release_address(req_release_address),
      .rsp_valid(rsp_valid), .rsp_granted_address(rsp_granted_address),
      .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // watchdog, ends a hung run
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == WATCHDOG_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // results cannot be stalled, so every strobe is checked on its closing edge
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_granted_address, rsp_status);
   end

   // one transaction, held until the allocator is not busy
   task automatic send_request(input logic op, input logic [23:0] want,
                               input logic [31:0] addr);
      int gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(1, 6);
         start = 0;
         repeat (gap) @(negedge clock);
      end
      start = 1;
      req_op = op;
      req_request_size = want;
      req_release_address = addr;
      // busy only moves on rising edges, so its value here holds to the next one
      while (busy) @(negedge clock);
      sb.note_request(op, want, addr);
      sent++;
      @(negedge clock);
   endtask

   // let all outstanding transactions finish before touching registers
   task automatic drain();
      start = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      drain();
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   task automatic alloc(input logic [23:0] want);
      send_request(OP_ALLOC, want, $urandom);
   endtask

   task automatic free_some();
      send_request(!OP_ALLOC, 24'($urandom), sb.some_used_address());
   endtask

   // mostly small sizes keep the tables churning; rare full-width sizes
   function automatic logic [23:0] random_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 80) return 24'($urandom_range(0, 64));
      if (roll < 95) return 24'($urandom_range(0, 4096));
      return 24'($urandom);
   endfunction

   task automatic random_block(input int count);
      int alloc_pct;
      int roll;
      logic [31:0] base;
      roll = $urandom_range(9);
      write_csr(CSR_FIT_POLICY, 32'($urandom_range(0, 3)));
      if (roll < 3) begin
         // tight heap window to provoke exhaustion
         base = $urandom;
         write_csr(CSR_HEAP_BASE, base);
         write_csr(CSR_HEAP_LIMIT, (base > 32'hFFFF_0000) ? 32'hFFFF_FFFF
                                                          : base + $urandom_range(0, 3000));
      end else if (roll == 3) begin
         write_csr(CSR_HEAP_LIMIT, 32'h0);
      end else if (roll == 4) begin
         write_csr(CSR_HEAP_BASE, 32'h0);
         write_csr(CSR_HEAP_LIMIT, 32'hFFFF_FFFF);
      end
      // the mix swings between filling the used table and filling the free one
      alloc_pct = $urandom_range(25, 85);
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < alloc_pct) alloc(random_size());
         else if (roll < 95) free_some();
         else send_request(!OP_ALLOC, 24'($urandom), $urandom);
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      sender_idle_pct = 15;
      sent = 0;
      reset = 1;
      start = 0;
      req_op = OP_ALLOC;
      req_request_size = 0;
      req_release_address = 0;
      csr_write_enable = 0;
      csr_index = CSR_FIT_POLICY;
      csr_write_data = 0;
      repeat (11) @(negedge clock);
      reset = 0;

      // directed: heap growth, zero size, releases, unknown address
      write_csr(CSR_HEAP_BASE, 32'h0000_1000);
      write_csr(CSR_HEAP_LIMIT, 32'h0010_0000);
      alloc(16);
      alloc(40);
      alloc(0);
      alloc(64);
      alloc(8);
      free_some();
      free_some();
      free_some();
      send_request(!OP_ALLOC, 24'hFFFFFF, 32'hDEAD_BEEF);
      alloc(4);                        // first fit split, top end granted
      write_csr(CSR_FIT_POLICY, POL_BEST);
      alloc(4);
      write_csr(CSR_FIT_POLICY, POL_WORST);
      alloc(4);
      write_csr(CSR_FIT_POLICY, 2'd3); // undefined code behaves as first fit
      alloc(2);
      alloc(24'hFFFFFF);               // beyond limit, heap exhausted
      write_csr(CSR_HEAP_LIMIT, 32'hFFFF_FFFF);
      write_csr(CSR_HEAP_BASE, 32'hFF00_0000);
      alloc(24'hFFFFFF);               // lands exactly on the limit
      alloc(1);
      write_csr(CSR_HEAP_LIMIT, 32'h0);
      alloc(0);
      free_some();
      free_some();
      alloc(0);                        // exact fit from the free list

      // random phases, sender gaps light then heavy then none
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 76 : 0;
         for (int b = 0; b < 5; b++) random_block(85);
      end

      drain();
      $display("%0d transactions sent, %0d results checked", sent, sb.checked);
      $display("status mix ok/unknown/full/exhausted: %0d/%0d/%0d/%0d",
               sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3]);
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
